[hdl/sq_pkg.sv]
package sq_pkg;

	localparam int unsigned DEPTH_DEF = 16;
	localparam int unsigned VALUE_W   = 32;
	localparam int unsigned POS_W     = 5;

	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_DELETE = 2'd1,
		MODE_SEARCH = 2'd2,
		MODE_NOP    = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_DELETE,
		FSM_SEARCH
	} fsm_t;

endpackage

[hdl/sq_req_if.sv]
interface sq_req_if import sq_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [1:0]                mode;
	logic signed [VALUE_W-1:0] value;

	modport source (output valid, mode, value, input ready);
	modport sink (input valid, mode, value, output ready);
endinterface

[hdl/sq_rsp_if.sv]
interface sq_rsp_if import sq_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [1:0]                status;
	logic signed [VALUE_W-1:0] removed_value;
	logic [POS_W-1:0]          position;

	modport source (output valid, status, removed_value, position, input ready);
	modport sink (input valid, status, removed_value, position, output ready);
endinterface

[hdl/sq_ram.sv]
module sq_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

[hdl/searchable_queue.sv]
// Bounded queue of up to DEPTH signed 32-bit values with a value search. Each
// request transaction is an insert at the front (newest), a delete from the
// rear (oldest, value returned) or a search that reports the 1-based position,
// counted from the front, of the first matching entry. Every request yields
// exactly one response transaction carrying a status (ok, empty, full, not
// found); mode 3 is a no-op that answers ok with zero fields. Values live in a
// circular buffer held in one single-port-write, registered-read RAM, with
// front and rear pointers and an occupancy count in flip-flops, so reset
// needs no clearing pass. Insert, no-op and any refused request load the
// output register in the cycle they are accepted; a delete reads the rear
// entry and answers from the DELETE state; a search enters the walk, then
// reads the RAM from the front one entry per cycle and answers on the first
// match or once every stored entry has been compared. A new request is taken
// once the previous one has finished and its response has left or is leaving
// the output register.
module searchable_queue import sq_pkg::*; #(
	parameter int unsigned DEPTH = DEPTH_DEF
) (
	input logic   clk,
	input logic   arst_n,
	sq_req_if.sink   req,
	sq_rsp_if.source rsp
);
	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned OCC_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(DEPTH);

	fsm_t state_q, state_d;

	// queue bookkeeping
	logic [PTR_W-1:0] rear_q;   // oldest entry
	logic [PTR_W-1:0] front_q;  // next free slot, one past the newest entry
	logic [OCC_W-1:0] occ_q;

	// search walk
	logic [PTR_W-1:0] scan_addr_q;
	logic [OCC_W-1:0] scan_k_q;
	logic             cmp_vld_s1;
	logic [OCC_W-1:0] cmp_k_s1;
	logic [VALUE_W-1:0] key_q;

	// ram ports
	logic               ram_we, ram_re;
	logic [PTR_W-1:0]   ram_raddr;
	logic [VALUE_W-1:0] ram_rdata;

	// output register
	logic               rsp_vld_q;
	logic [1:0]         rsp_status_q;
	logic [VALUE_W-1:0] rsp_removed_q;
	logic [POS_W-1:0]   rsp_pos_q;

	// result load from the control block
	logic               ld;
	status_t            ld_status;
	logic [VALUE_W-1:0] ld_removed;
	logic [POS_W-1:0]   ld_pos;

	logic    accept, is_full, is_empty, scan_issue, hit, last_cmp;
	mode_t   req_mode;

	assign req_mode   = mode_t'(req.mode);
	assign accept     = req.valid && req.ready;
	assign is_full    = (occ_q == OCC_FULL);
	assign is_empty   = (occ_q == '0);
	assign hit        = cmp_vld_s1 && (ram_rdata == key_q);
	assign last_cmp   = cmp_vld_s1 && (cmp_k_s1 == occ_q);
	// keep issuing reads until every entry has been fetched or the walk ends
	assign scan_issue = (state_q == FSM_SEARCH) && !hit && !last_cmp && (scan_k_q <= occ_q);

	// take a request only when idle and the output slot is empty or frees up this cycle
	assign req.ready = (state_q == FSM_IDLE) && (!rsp_vld_q || rsp.ready);

	assign ram_we = accept && (req_mode == MODE_INSERT) && !is_full;

	always_comb begin
		state_d    = state_q;
		ld         = 1'b0;
		ld_status  = ST_OK;
		ld_removed = '0;
		ld_pos     = '0;
		ram_re     = 1'b0;
		ram_raddr  = scan_addr_q;
		unique case (state_q)
			FSM_IDLE: begin
				if (accept) begin
					unique case (req_mode)
						MODE_INSERT: begin
							ld        = 1'b1;
							ld_status = is_full ? ST_FULL : ST_OK;
						end
						MODE_DELETE: begin
							if (is_empty) begin
								ld        = 1'b1;
								ld_status = ST_EMPTY;
							end else begin
								ram_re    = 1'b1;
								ram_raddr = rear_q;
								state_d   = FSM_DELETE;
							end
						end
						MODE_SEARCH: begin
							if (is_empty) begin
								ld        = 1'b1;
								ld_status = ST_EMPTY;
							end else begin
								state_d = FSM_SEARCH;
							end
						end
						MODE_NOP: begin
							ld = 1'b1;
						end
						default: begin
							ld = 1'b1;
						end
					endcase
				end
			end
			FSM_DELETE: begin
				ld         = 1'b1;
				ld_removed = ram_rdata;
				state_d    = FSM_IDLE;
			end
			FSM_SEARCH: begin
				ram_re = scan_issue;
				if (hit) begin
					ld      = 1'b1;
					ld_pos  = POS_W'(cmp_k_s1);
					state_d = FSM_IDLE;
				end else if (last_cmp) begin
					ld        = 1'b1;
					ld_status = ST_NOTFOUND;
					state_d   = FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// pointers and occupancy: commit at request acceptance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rear_q     <= '0;
			front_q    <= '0;
			occ_q      <= '0;
			cmp_vld_s1 <= 1'b0;
			rsp_vld_q  <= 1'b0;
		end else begin
			cmp_vld_s1 <= scan_issue;
			if (ram_we) begin
				front_q <= (front_q == PTR_LAST) ? '0 : front_q + 1'b1;
				occ_q   <= occ_q + 1'b1;
			end
			if (accept && (req_mode == MODE_DELETE) && !is_empty) begin
				rear_q <= (rear_q == PTR_LAST) ? '0 : rear_q + 1'b1;
				occ_q  <= occ_q - 1'b1;
			end
			if (ld) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	// payload and walk registers
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q       <= req.value;
			scan_k_q    <= OCC_W'(1);
			// start at the newest entry
			scan_addr_q <= (front_q == '0) ? PTR_LAST : front_q - 1'b1;
		end else if (scan_issue) begin
			scan_k_q    <= scan_k_q + 1'b1;
			scan_addr_q <= (scan_addr_q == '0) ? PTR_LAST : scan_addr_q - 1'b1;
		end
		cmp_k_s1 <= scan_k_q;
		if (ld) begin
			rsp_status_q  <= ld_status;
			rsp_removed_q <= ld_removed;
			rsp_pos_q     <= ld_pos;
		end
	end

	sq_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(front_q),
		.wdata(req.value),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rsp.valid         = rsp_vld_q;
	assign rsp.status        = rsp_status_q;
	assign rsp.removed_value = rsp_removed_q;
	assign rsp.position      = rsp_pos_q;

	// occupancy never exceeds capacity
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_FULL)
		else $error("occupancy above capacity");

	// a taken request never overwrites an unconsumed response
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (!rsp_vld_q || rsp.ready))
		else $error("response overrun");

	// a successful insert grows the queue by one
	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> occ_q == $past(occ_q) + 1'b1)
		else $error("insert did not advance occupancy");

	// full status only issues when the queue is at capacity
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(ld && ld_status == ST_FULL) |-> is_full)
		else $error("full reported below capacity");

	// pointers differ whenever the queue is neither full nor empty
	a_ptr_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(!is_full && !is_empty) |-> (front_q != rear_q))
		else $error("pointers collide with partial occupancy");
endmodule

[dv/searchable_queue_tb.sv]
`timescale 1ns / 100ps

module searchable_queue_tb;
	import sq_pkg::*;

	localparam int unsigned DEPTH       = DEPTH_DEF;
	// Safety net only.
	localparam int unsigned CYCLE_LIMIT = 500000;
	// Settle time at the end: a full search walk plus the output register.
	localparam int unsigned TAIL_CYCLES = 2 * DEPTH + 8;

	// One response as the block should produce it.
	typedef struct {
		status_t                   status;
		logic signed [VALUE_W-1:0] removed_value;
		logic [POS_W-1:0]          position;
	} sq_result_t;

	logic clk;
	logic arst_n;

	sq_req_if req_if ();
	sq_rsp_if rsp_if ();

	searchable_queue #(.DEPTH(DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if.sink),
		.rsp    (rsp_if.source)
	);

	// Predicted contents: index 0 is the front (newest), the last index the rear.
	logic signed [VALUE_W-1:0] queue_image[$];
	// Responses owed by the block, oldest first.
	sq_result_t                pending_results[$];

	int unsigned error_count;
	int unsigned cycle_count;
	bit          idle_on;
	int unsigned rsp_hold_left;
	int unsigned rsp_stall_left;

	// Values that repeat often so that searches hit and duplicates occur.
	logic signed [VALUE_W-1:0] value_pool[8];

	// 20 ns clock.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Drive every input to a known value from time zero, then hold reset
	// and release it on a falling edge.
	initial begin
		arst_n        = 1'b0;
		req_if.valid  = 1'b0;
		req_if.mode   = MODE_INSERT;
		req_if.value  = '0;
		rsp_if.ready  = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
	end

	// Watchdog: end the run once the cycle count passes CYCLE_LIMIT.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d responses outstanding", $time,
				pending_results.size());
			$display("status: fail");
			$finish;
		end
	end

	// Response ready. A long hold requested by a test task wins over the
	// random stall bursts; only the counter in charge is decremented here.
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
		end else if (rsp_hold_left != 0) begin
			rsp_if.ready <= 1'b0;
			rsp_hold_left = rsp_hold_left - 1;
		end else if (rsp_stall_left != 0) begin
			rsp_if.ready <= 1'b0;
			rsp_stall_left = rsp_stall_left - 1;
		end else if (idle_on && ($urandom_range(0, 6) == 0)) begin
			// Start a stall burst that includes this cycle.
			rsp_if.ready <= 1'b0;
			rsp_stall_left = $urandom_range(1, 13) - 1;
		end else begin
			rsp_if.ready <= 1'b1;
		end
	end

	// Work out the response to one accepted request and apply it to the
	// predicted contents.
	task automatic predict_queue_op(input logic [1:0] mode, input logic signed [VALUE_W-1:0] value);
		sq_result_t res;
		int         hit;
		res.status        = ST_OK;
		res.removed_value = '0;
		res.position      = '0;
		case (mode)
			MODE_INSERT: begin
				if (queue_image.size() >= DEPTH)
					res.status = ST_FULL;
				else
					queue_image.push_front(value);
			end
			MODE_DELETE: begin
				if (queue_image.size() == 0)
					res.status = ST_EMPTY;
				else
					res.removed_value = queue_image.pop_back();
			end
			MODE_SEARCH: begin
				if (queue_image.size() == 0) begin
					res.status = ST_EMPTY;
				end else begin
					// First match counted from the front, 1-based.
					hit = -1;
					for (int i = 0; i < queue_image.size(); i++) begin
						if (hit < 0 && queue_image[i] == value)
							hit = i;
					end
					if (hit < 0)
						res.status = ST_NOTFOUND;
					else
						res.position = POS_W'(hit + 1);
				end
			end
			default: ; // unused mode: store unchanged, all-zero ok response
		endcase
		pending_results.push_back(res);
	endtask

	// Offer one request and wait for its transaction; with idling on, a
	// random gap with valid low may come first.
	task automatic send_req(input logic [1:0] mode, input logic signed [VALUE_W-1:0] value);
		if (idle_on && ($urandom_range(0, 5) == 0)) begin
			@(negedge clk);
			req_if.valid <= 1'b0;
			repeat ($urandom_range(1, 13) - 1) @(negedge clk);
		end
		@(negedge clk);
		req_if.valid <= 1'b1;
		req_if.mode  <= mode;
		req_if.value <= value;
		@(posedge clk);
		while (!req_if.ready) @(posedge clk);
		predict_queue_op(mode, value);
	endtask

	// Drop valid and hold off until every owed response has arrived.
	task automatic wait_drained();
		@(negedge clk);
		req_if.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// Compare one response transaction with the oldest expectation.
	task automatic check_response();
		sq_result_t want;
		if (pending_results.size() == 0) begin
			$display("%0t: unexpected response status=%0d removed=%0d position=%0d",
				$time, rsp_if.status, rsp_if.removed_value, rsp_if.position);
			error_count++;
			return;
		end
		want = pending_results.pop_front();
		if (rsp_if.status !== want.status) begin
			$display("%0t: status mismatch expected %0d actual %0d",
				$time, want.status, rsp_if.status);
			error_count++;
		end
		if (rsp_if.removed_value !== want.removed_value) begin
			$display("%0t: removed_value mismatch expected %0d actual %0d",
				$time, want.removed_value, rsp_if.removed_value);
			error_count++;
		end
		if (rsp_if.position !== want.position) begin
			$display("%0t: position mismatch expected %0d actual %0d",
				$time, want.position, rsp_if.position);
			error_count++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
			check_response();
	end

	// Requests against an empty store, and the unused mode.
	task automatic test_empty_store();
		send_req(MODE_SEARCH, 32'sd7);
		send_req(MODE_DELETE, -32'sd1);
		send_req(MODE_NOP, -32'sd1);
	endtask

	// Extreme values in and out, hits at several positions and a miss.
	task automatic test_extremes();
		send_req(MODE_INSERT, 32'sh8000_0000);
		send_req(MODE_INSERT, 32'sh7fff_ffff);
		send_req(MODE_INSERT, 32'sd0);
		send_req(MODE_INSERT, -32'sd1);
		send_req(MODE_SEARCH, 32'sh7fff_ffff);
		send_req(MODE_SEARCH, 32'sh8000_0000);
		send_req(MODE_SEARCH, -32'sd1);
		send_req(MODE_SEARCH, 32'sd5);
		send_req(MODE_DELETE, 32'sh5555_5555);
		send_req(MODE_DELETE, 32'shaaaa_aaaa);
		send_req(MODE_NOP, 32'sd0);
		send_req(MODE_SEARCH, 32'sd0);
	endtask

	// Fill to capacity with distinct values, get an insert refused, and find
	// the rear entry at the deepest position.
	task automatic test_full_store();
		while (queue_image.size() < DEPTH)
			send_req(MODE_INSERT, 32'(1000 + queue_image.size()));
		send_req(MODE_INSERT, 32'sd12345);
		send_req(MODE_SEARCH, queue_image[queue_image.size() - 1]);
	endtask

	// Pick one request: mostly well-formed traffic that drifts between
	// filling and draining, so both full and empty are reached often.
	task automatic random_request(input bit filling);
		int unsigned               r;
		logic [1:0]                mode;
		logic signed [VALUE_W-1:0] value;
		r = $urandom_range(0, 99);
		if (r < 5)
			mode = MODE_NOP;
		else if (r < 25)
			mode = MODE_SEARCH;
		else if (r < (filling ? 80 : 40))
			mode = MODE_INSERT;
		else
			mode = MODE_DELETE;
		if ($urandom_range(0, 9) < 6)
			value = value_pool[$urandom_range(0, 7)];
		else
			value = $urandom;
		// Most searches look for something that is actually stored.
		if (mode == MODE_SEARCH && queue_image.size() != 0 && $urandom_range(0, 9) < 7)
			value = queue_image[$urandom_range(0, queue_image.size() - 1)];
		send_req(mode, value);
	endtask

	// Let the response side back up for a long stretch while requests keep
	// coming, then pause the sender until everything has drained.
	task automatic test_backpressure();
		wait_drained();
		rsp_hold_left = 120;
		repeat (15) random_request(1'($urandom_range(0, 1)));
		wait_drained();
	endtask

	// Random traffic with idling on both sides, in stretches with and without.
	task automatic test_random_traffic();
		bit filling;
		filling = 1'b0;
		for (int n = 0; n < 550; n++) begin
			if (n % 40 == 0)
				filling = ~filling;
			if (n % 60 == 0)
				idle_on = ($urandom_range(0, 3) != 0);
			random_request(filling);
		end
		wait_drained();
	endtask

	// Closing stretch at full rate: no idling on either side.
	task automatic test_back_to_back();
		bit filling;
		idle_on = 1'b0;
		filling = 1'b1;
		for (int n = 0; n < 250; n++) begin
			if (n % 30 == 0)
				filling = ~filling;
			random_request(filling);
		end
	endtask

	initial begin
		error_count    = 0;
		cycle_count    = 0;
		rsp_hold_left  = 0;
		rsp_stall_left = 0;
		idle_on        = 1'b1;
		value_pool[0]  = 32'sd0;
		value_pool[1]  = -32'sd1;
		value_pool[2]  = 32'sd1;
		value_pool[3]  = 32'sh7fff_ffff;
		value_pool[4]  = 32'sh8000_0000;
		value_pool[5]  = 32'sd42;
		value_pool[6]  = $urandom;
		value_pool[7]  = $urandom;

		@(posedge arst_n);
		test_empty_store();
		test_extremes();
		test_full_store();
		test_backpressure();
		test_random_traffic();
		test_back_to_back();

		// All requests are in; wait for the last responses, then settle.
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			$display("%0t: %0d responses never arrived", $time, pending_results.size());
			error_count++;
		end
		if (error_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

[filelist.f]
hdl/sq_pkg.sv
hdl/sq_req_if.sv
hdl/sq_rsp_if.sv
hdl/sq_ram.sv
hdl/searchable_queue.sv
dv/searchable_queue_tb.sv
